>>> hw/rtl/caf_pkg.sv
// caf_pkg: shared types, widths and constants of the complementary attitude filter
// no dependencies; imported by every module of the block

package caf_pkg;

  localparam int OUT_W        = 19;  // output angle width
  localparam int ACC_W        = 17;  // accel operand, room for a negated minimum
  localparam int DEN_W        = 26;  // divisor width, holds 256*131*1000
  localparam int TILT_W       = 26;  // cordic angle in 2^-16 degree
  localparam int CORDIC_W     = 36;  // cordic vector width
  localparam int CORDIC_STEPS = 16;
  localparam int EST1_W       = 28;  // estimate after gyro integration
  localparam int SUM_W        = 24;  // calibration sums and biases
  localparam int RECIP_W      = 40;  // rounded-up reciprocal of a constant divisor

  localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sh3FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sh40000;

  localparam logic [DEN_W-1:0] DEN_GYRO_131 = DEN_W'(256 * 131 * 1000);
  localparam logic [DEN_W-1:0] DEN_GYRO_114 = DEN_W'(256 * 114 * 1000);
  localparam logic [DEN_W-1:0] DEN_MIX      = DEN_W'(50);

  typedef enum logic [2:0] {
    JOB_BIAS_X,
    JOB_BIAS_Y,
    JOB_INC_P,
    JOB_MIX_P,
    JOB_INC_R,
    JOB_MIX_R
  } job_t;

  typedef struct packed {
    logic accept;
    logic cordic_start;
    logic cordic_roll;
    logic div_start;
    job_t job;
    logic out_load;
  } caf_cmd_t;

  typedef struct packed {
    logic cal_only;
    logic bias_due;
    logic cordic_done;
    logic div_done;
  } caf_status_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [21:0] atan_entry(input logic [3:0] idx);
    logic [21:0] v;
    unique case (idx)
      4'd0:  v = 22'd2949120;
      4'd1:  v = 22'd1740967;
      4'd2:  v = 22'd919879;
      4'd3:  v = 22'd466945;
      4'd4:  v = 22'd234379;
      4'd5:  v = 22'd117304;
      4'd6:  v = 22'd58666;
      4'd7:  v = 22'd29335;
      4'd8:  v = 22'd14668;
      4'd9:  v = 22'd7334;
      4'd10: v = 22'd3667;
      4'd11: v = 22'd1833;
      4'd12: v = 22'd917;
      4'd13: v = 22'd458;
      4'd14: v = 22'd229;
      4'd15: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/complementary_attitude_filter_unit.sv
// complementary_attitude_filter_unit: top level of the pitch/roll complementary filter
// depends on caf_pkg, caf_ctrl and caf_datapath
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   cfg     | cfg_wr_en            | cfg_wr_data (gyro sensitivity select)
//   in      | in_valid / in_ready  | in_gyro_x/y, in_acc_x/y/z, in_time_ms
//   out     | out_valid / out_ready| out_pitch_angle, out_roll_angle, out_calibrated
//
// one sample at a time: a plain calibration sample goes straight to the output; the
// last one first runs two bias divisions, and a filter sample runs the 16-step cordic
// for pitch, then for roll, and four divisions (increment and mix, pitch then roll) on
// the reciprocal multiplier, one 16-bit slice a cycle
// synchronous active-low reset clears all filter state and the configuration register
// the finished transaction waits in an output register; in_ready is high while idle,
// and a result only stalls the sequencer if the previous one has not been taken

module complementary_attitude_filter_unit #(
  parameter int CAL_SAMPLES     = 200,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 in_gyro_x,
  input  logic signed [15:0]                 in_gyro_y,
  input  logic signed [15:0]                 in_acc_x,
  input  logic signed [15:0]                 in_acc_y,
  input  logic signed [15:0]                 in_acc_z,
  input  logic [31:0]                        in_time_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [caf_pkg::OUT_W-1:0]   out_pitch_angle,
  output logic signed [caf_pkg::OUT_W-1:0]   out_roll_angle,
  output logic                               out_calibrated
);
  import caf_pkg::*;

  caf_cmd_t    cmd;
  caf_status_t status;

  caf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  caf_datapath #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .FRAC_BITS   (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .gyro_x_i      (in_gyro_x),
    .gyro_y_i      (in_gyro_y),
    .acc_x_i       (in_acc_x),
    .acc_y_i       (in_acc_y),
    .acc_z_i       (in_acc_z),
    .time_ms_i     (in_time_ms),
    .pitch_angle_o (out_pitch_angle),
    .roll_angle_o  (out_roll_angle),
    .calibrated_o  (out_calibrated)
  );

`ifndef SYNTH
  // calibration, once reached, is never lost
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(out_calibrated)) else $error("calibrated flag dropped");

  // angles stay at zero until the bias is known
  a_zero_uncal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_calibrated |-> out_pitch_angle == '0 && out_roll_angle == '0)
    else $error("angle moved before calibration");

  // a transaction taken in lowers in_ready in the cycle after, blocking the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second sample taken while busy");
`endif

endmodule

>>> hw/rtl/caf_cordic.sv
// caf_cordic: iterative vectoring cordic, atan2 in degrees, one step per cycle
// depends on caf_pkg

module caf_cordic #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start_i,
  input  logic signed [caf_pkg::ACC_W-1:0]    y_i,
  input  logic signed [caf_pkg::ACC_W-1:0]    x_i,
  output logic signed [caf_pkg::TILT_W-1:0]   angle_o,
  output logic                                done_o
);
  import caf_pkg::*;

  localparam int SH = 16 - FRAC_BITS;
  localparam logic signed [TILT_W-1:0] Z_HALF = TILT_W'(180 * 65536);

  logic signed [CORDIC_W-1:0] xv_r, yv_r, xv_nxt, yv_nxt;
  logic signed [CORDIC_W-1:0] xs, ys, dx, dy;
  logic signed [TILT_W-1:0]   z_r, z_nxt, t, z_rnd;
  logic [3:0]                 step_r;
  logic                       busy_r, done_r, zero_r;

  assign xs = CORDIC_W'(x_i) <<< 16;
  assign ys = CORDIC_W'(y_i) <<< 16;
  assign dx = yv_r >>> step_r;
  assign dy = xv_r >>> step_r;
  assign t  = signed'(TILT_W'(atan_entry(step_r)));

  always_comb begin
    if (!yv_r[CORDIC_W-1]) begin
      xv_nxt = xv_r + dx;
      yv_nxt = yv_r - dy;
      z_nxt  = z_r + t;
    end else begin
      xv_nxt = xv_r - dx;
      yv_nxt = yv_r + dy;
      z_nxt  = z_r - t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= '0;
        zero_r <= (x_i == '0) && (y_i == '0);
        if (x_i[ACC_W-1]) begin
          xv_r <= -xs;
          yv_r <= -ys;
          z_r  <= y_i[ACC_W-1] ? -Z_HALF : Z_HALF;
        end else begin
          xv_r <= xs;
          yv_r <= ys;
          z_r  <= '0;
        end
      end else if (busy_r) begin
        xv_r <= xv_nxt;
        yv_r <= yv_nxt;
        z_r  <= z_nxt;
        if (step_r == 4'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 4'd1;
        end
      end
    end
  end

  generate
    if (SH == 0) begin : g_nornd
      assign z_rnd = z_r;
    end else begin : g_rnd
      localparam logic signed [TILT_W-1:0] ZR = TILT_W'(1) << (SH - 1);
      assign z_rnd = (z_r + ZR) >>> SH;
    end
  endgenerate

  assign angle_o = zero_r ? '0 : z_rnd;
  assign done_o  = done_r;

endmodule

>>> hw/rtl/caf_div.sv
// caf_div: division by a constant as a multiply by its rounded-up reciprocal,
// one 16-bit numerator slice per cycle, most significant slice first
// depends on caf_pkg

module caf_div #(
  parameter int DW = 40
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_i,
  input  logic [DW-1:0]                     num_i,
  input  logic [caf_pkg::RECIP_W-1:0]       recip_i,
  output logic [DW+caf_pkg::RECIP_W-1:0]    prod_o,
  output logic                              done_o
);
  import caf_pkg::*;

  localparam int NC = (DW + 15) / 16;
  localparam int NW = 16 * NC;
  localparam int PW = NW + RECIP_W;
  localparam int CW = $clog2(NC + 1);

  logic [NW-1:0]        num_r;
  logic [RECIP_W-1:0]   recip_r;
  logic [PW-1:0]        acc_r;
  logic [15:0]          slice;
  logic [RECIP_W+15:0]  mul;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r, done_r;

  assign slice = num_r[NW-1 -: 16];
  assign mul   = (RECIP_W+16)'(slice) * (RECIP_W+16)'(recip_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        num_r   <= NW'(num_i);
        recip_r <= recip_i;
        acc_r   <= '0;
        cnt_r   <= CW'(NC);
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        acc_r <= (acc_r << 16) + PW'(mul);
        num_r <= num_r << 16;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod_o = acc_r[DW+RECIP_W-1:0];
  assign done_o = done_r;

endmodule

>>> hw/rtl/caf_datapath.sv
// caf_datapath: filter state, sample registers, operand selection and result write-back
// depends on caf_pkg, caf_cordic and caf_div

module caf_datapath #(
  parameter int CAL_SAMPLES = 200,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  caf_pkg::caf_cmd_t                    cmd_i,
  output caf_pkg::caf_status_t                 status_o,
  input  logic                                 cfg_wr_en_i,
  input  logic                                 cfg_wr_data_i,
  input  logic signed [15:0]                   gyro_x_i,
  input  logic signed [15:0]                   gyro_y_i,
  input  logic signed [15:0]                   acc_x_i,
  input  logic signed [15:0]                   acc_y_i,
  input  logic signed [15:0]                   acc_z_i,
  input  logic [31:0]                          time_ms_i,
  output logic signed [caf_pkg::OUT_W-1:0]     pitch_angle_o,
  output logic signed [caf_pkg::OUT_W-1:0]     roll_angle_o,
  output logic                                 calibrated_o
);
  import caf_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int VW = DW + 1;
  localparam int MW = EST1_W + 7;
  localparam logic [7:0] CAL_N = 8'(CAL_SAMPLES);

  // reciprocal shifts: numerator bound times divisor bound stays below 2^K
  localparam int K_BIAS = 39;
  localparam int K_INC  = 39 + FRAC_BITS;
  localparam int K_MIX  = 33;
  localparam logic [63:0] ONE    = 64'd1;
  localparam logic [63:0] D_BIAS = 64'(CAL_N);
  localparam logic [63:0] D_131  = 64'(DEN_GYRO_131 >> 8);
  localparam logic [63:0] D_114  = 64'(DEN_GYRO_114 >> 8);
  localparam logic [63:0] D_MIX  = 64'(DEN_MIX);
  localparam logic [RECIP_W-1:0] M_BIAS = RECIP_W'(((ONE << K_BIAS) + D_BIAS - ONE) / D_BIAS);
  localparam logic [RECIP_W-1:0] M_131  = RECIP_W'(((ONE << K_INC) + D_131 - ONE) / D_131);
  localparam logic [RECIP_W-1:0] M_114  = RECIP_W'(((ONE << K_INC) + D_114 - ONE) / D_114);
  localparam logic [RECIP_W-1:0] M_MIX  = RECIP_W'(((ONE << K_MIX) + D_MIX - ONE) / D_MIX);

  // filter state
  logic signed [OUT_W-1:0]  pitch_est_r, roll_est_r;
  logic signed [SUM_W-1:0]  bias_x_r, bias_y_r, sum_x_r, sum_y_r;
  logic [7:0]               cal_count_r;
  logic [31:0]              last_time_r;
  logic                     gyro_sel_r;
  logic                     cal_only_r, bias_due_r;

  // sample and intermediate registers
  logic signed [15:0]       gx_r, gy_r, ax_r, ay_r, az_r;
  logic [5:0]               dt_r;
  logic signed [TILT_W-1:0] tilt_p_r, tilt_r_r;
  logic signed [EST1_W-1:0] est1_r;
  logic                     croll_r, neg_r;
  job_t                     job_r;

  logic signed [OUT_W-1:0]  out_pitch_r, out_roll_r;
  logic                     out_cal_r;

  logic [31:0]              tdiff;
  logic [5:0]               dt_nxt;
  logic [7:0]               count_inc;

  always_comb begin
    tdiff = time_ms_i - last_time_r;
    if (last_time_r == '0)
      dt_nxt = 6'd10;
    else if (tdiff > 32'd50)
      dt_nxt = 6'd50;
    else
      dt_nxt = tdiff[5:0];
  end

  assign count_inc = cal_count_r + 8'd1;

  // cordic operands
  logic signed [ACC_W-1:0]  cy, cx;
  logic signed [TILT_W-1:0] c_angle;
  logic                     c_done;

  assign cy = cmd_i.cordic_roll ? ACC_W'(ay_r) : -ACC_W'(ax_r);
  assign cx = ACC_W'(az_r);

  caf_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.cordic_start),
    .y_i     (cy),
    .x_i     (cx),
    .angle_o (c_angle),
    .done_o  (c_done)
  );

  // divider operands
  logic signed [25:0]       gdiff;
  logic signed [32:0]       gprod;
  logic signed [MW-1:0]     m49;
  logic signed [VW-1:0]     v, vmag;
  logic [DEN_W-1:0]         den;
  logic [RECIP_W-1:0]       recip;
  logic [DW-1:0]            d_num, m_num, d_quo;
  logic [DW+RECIP_W-1:0]    d_prod;
  logic                     d_done;
  logic signed [15:0]       g_sel;
  logic signed [SUM_W-1:0]  b_sel;
  logic signed [TILT_W-1:0] t_sel;
  logic [DEN_W-1:0]         den_gyro;
  logic [RECIP_W-1:0]       recip_gyro;

  assign den_gyro   = gyro_sel_r ? DEN_GYRO_114 : DEN_GYRO_131;
  assign recip_gyro = gyro_sel_r ? M_114 : M_131;

  always_comb begin
    if (cmd_i.job == JOB_INC_R) begin
      g_sel = gx_r;
      b_sel = bias_x_r;
    end else begin
      g_sel = gy_r;
      b_sel = bias_y_r;
    end
    t_sel = (cmd_i.job == JOB_MIX_R) ? tilt_r_r : tilt_p_r;
    gdiff = (26'(g_sel) <<< 8) - 26'(b_sel);
    gprod = 33'(gdiff) * signed'({27'd0, dt_r});
    m49   = MW'(est1_r) * MW'(49);
    unique case (cmd_i.job)
      JOB_BIAS_X: begin
        v     = VW'(sum_x_r) <<< 8;
        den   = DEN_W'(CAL_N);
        recip = M_BIAS;
      end
      JOB_BIAS_Y: begin
        v     = VW'(sum_y_r) <<< 8;
        den   = DEN_W'(CAL_N);
        recip = M_BIAS;
      end
      JOB_INC_P, JOB_INC_R: begin
        v     = VW'(gprod) <<< FRAC_BITS;
        den   = den_gyro;
        recip = recip_gyro;
      end
      JOB_MIX_P, JOB_MIX_R: begin
        v     = VW'(m49) + VW'(t_sel);
        den   = DEN_MIX;
        recip = M_MIX;
      end
      default: begin
        v     = '0;
        den   = DEN_MIX;
        recip = M_MIX;
      end
    endcase
    vmag  = v[VW-1] ? -v : v;
    // round half away from zero on the magnitude
    d_num = vmag[DW-1:0] + DW'(den >> 1);
    // the gyro divisor carries a factor of 256, taken off the numerator first
    m_num = (cmd_i.job == JOB_INC_P || cmd_i.job == JOB_INC_R) ? (d_num >> 8) : d_num;
  end

  caf_div #(.DW(DW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.div_start),
    .num_i   (m_num),
    .recip_i (recip),
    .prod_o  (d_prod),
    .done_o  (d_done)
  );

  always_comb begin
    unique case (job_r)
      JOB_BIAS_X, JOB_BIAS_Y: d_quo = DW'(d_prod >> K_BIAS);
      JOB_INC_P, JOB_INC_R:   d_quo = DW'(d_prod >> K_INC);
      default:                d_quo = DW'(d_prod >> K_MIX);
    endcase
  end

  logic signed [VW-1:0]     qs;
  logic signed [OUT_W-1:0]  qsat;
  logic signed [EST1_W-1:0] qinc;

  always_comb begin
    qs   = neg_r ? -signed'({1'b0, d_quo}) : signed'({1'b0, d_quo});
    qinc = signed'(qs[EST1_W-1:0]);
    if (qs > VW'(OUT_MAX))
      qsat = OUT_MAX;
    else if (qs < VW'(OUT_MIN))
      qsat = OUT_MIN;
    else
      qsat = qs[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_est_r <= '0;
      roll_est_r  <= '0;
      bias_x_r    <= '0;
      bias_y_r    <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      cal_count_r <= '0;
      last_time_r <= '0;
      gyro_sel_r  <= 1'b0;
      cal_only_r  <= 1'b0;
      bias_due_r  <= 1'b0;
      out_cal_r   <= 1'b0;
    end else begin
      if (cfg_wr_en_i)
        gyro_sel_r <= cfg_wr_data_i;

      if (cmd_i.accept) begin
        gx_r        <= gyro_x_i;
        gy_r        <= gyro_y_i;
        ax_r        <= acc_x_i;
        ay_r        <= acc_y_i;
        az_r        <= acc_z_i;
        dt_r        <= dt_nxt;
        last_time_r <= time_ms_i;
        if (cal_count_r < CAL_N) begin
          sum_x_r     <= sum_x_r + SUM_W'(gyro_x_i);
          sum_y_r     <= sum_y_r + SUM_W'(gyro_y_i);
          cal_count_r <= count_inc;
          cal_only_r  <= 1'b1;
          bias_due_r  <= (count_inc == CAL_N);
        end else begin
          cal_only_r  <= 1'b0;
          bias_due_r  <= 1'b0;
        end
      end

      if (cmd_i.cordic_start)
        croll_r <= cmd_i.cordic_roll;
      if (c_done) begin
        if (croll_r)
          tilt_r_r <= c_angle;
        else
          tilt_p_r <= c_angle;
      end

      if (cmd_i.div_start) begin
        job_r <= cmd_i.job;
        neg_r <= v[VW-1];
      end
      if (d_done) begin
        unique case (job_r)
          JOB_BIAS_X: bias_x_r    <= qs[SUM_W-1:0];
          JOB_BIAS_Y: bias_y_r    <= qs[SUM_W-1:0];
          JOB_INC_P:  est1_r      <= EST1_W'(pitch_est_r) + qinc;
          JOB_INC_R:  est1_r      <= EST1_W'(roll_est_r) + qinc;
          JOB_MIX_P:  pitch_est_r <= qsat;
          JOB_MIX_R:  roll_est_r  <= qsat;
          default:    ;
        endcase
      end

      if (cmd_i.out_load) begin
        out_pitch_r <= pitch_est_r;
        out_roll_r  <= roll_est_r;
        out_cal_r   <= (cal_count_r >= CAL_N);
      end
    end
  end

  assign status_o.cal_only    = cal_only_r;
  assign status_o.bias_due    = bias_due_r;
  assign status_o.cordic_done = c_done;
  assign status_o.div_done    = d_done;

  assign pitch_angle_o = out_pitch_r;
  assign roll_angle_o  = out_roll_r;
  assign calibrated_o  = out_cal_r;

endmodule

>>> hw/rtl/caf_ctrl.sv
// caf_ctrl: sequencer for one sample, issues cordic and divider jobs, owns both handshakes
// depends on caf_pkg

module caf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  caf_pkg::caf_status_t  status_i,
  output caf_pkg::caf_cmd_t     cmd_o
);
  import caf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_TILT_P,
    S_TILT_R,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r;
  job_t   job_r;
  logic   cstart_r, croll_r, dstart_r, out_valid_r;
  logic   out_load;

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_BIAS_X;
      cstart_r    <= 1'b0;
      croll_r     <= 1'b0;
      dstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cstart_r <= 1'b0;
      dstart_r <= 1'b0;
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid)
            state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          priority if (status_i.bias_due) begin
            job_r    <= JOB_BIAS_X;
            dstart_r <= 1'b1;
            state_r  <= S_DIV;
          end else if (status_i.cal_only) begin
            state_r <= S_OUT;
          end else begin
            cstart_r <= 1'b1;
            croll_r  <= 1'b0;
            state_r  <= S_TILT_P;
          end
        end
        S_TILT_P: begin
          if (status_i.cordic_done) begin
            cstart_r <= 1'b1;
            croll_r  <= 1'b1;
            state_r  <= S_TILT_R;
          end
        end
        S_TILT_R: begin
          if (status_i.cordic_done) begin
            job_r    <= JOB_INC_P;
            dstart_r <= 1'b1;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (status_i.div_done) begin
            unique case (job_r)
              JOB_BIAS_X: begin
                job_r    <= JOB_BIAS_Y;
                dstart_r <= 1'b1;
              end
              JOB_INC_P: begin
                job_r    <= JOB_MIX_P;
                dstart_r <= 1'b1;
              end
              JOB_MIX_P: begin
                job_r    <= JOB_INC_R;
                dstart_r <= 1'b1;
              end
              JOB_INC_R: begin
                job_r    <= JOB_MIX_R;
                dstart_r <= 1'b1;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_OUT: begin
          if (out_load)
            state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign cmd_o.accept       = in_valid && (state_r == S_IDLE);
  assign cmd_o.cordic_start = cstart_r;
  assign cmd_o.cordic_roll  = croll_r;
  assign cmd_o.div_start    = dstart_r;
  assign cmd_o.job          = job_r;
  assign cmd_o.out_load     = out_load;

endmodule
